### hw/rtl/eas_pkg.sv
// Shared constants and types for the equal-area sphere-to-square mapper.
`default_nettype none
package eas_pkg;
    localparam int WF = 30;
    typedef logic [30:0] q30_t;
    localparam logic signed [31:0] POLY [7] = '{
        32'sd4368, 32'sd683143051, 32'sd6611245, -32'sd265572574,
        32'sd94679404, 32'sd44993950, -32'sd26992900
    };
    localparam q30_t ONE_W = 31'h4000_0000;
endpackage
`default_nettype wire

### hw/rtl/equal_area_sphere_to_square.sv
// Top level: equal-area sphere-to-square mapper, fully pipelined.
// Pipeline: 31 divide/root stages, 6 Horner stages and
// 11 stages of phi, mirror and output scaling.
// Throughput: one word per cycle; busy is tied low and the receiver cannot stall.
// Reset: rst_n clears the valid chain only; data registers are not reset.
`default_nettype none
module equal_area_sphere_to_square #(
    parameter int IN_FRAC_BITS  = 14,
    parameter int OUT_FRAC_BITS = 16
) (
    input  wire  logic               clk,
    input  wire  logic               rst_n,
    input  wire  logic               start,
    output logic                     busy,
    input  wire  logic signed [15:0] dir_x,
    input  wire  logic signed [15:0] dir_y,
    input  wire  logic signed [15:0] dir_z,
    output logic                     done,
    output logic [16:0]              coord_u,
    output logic [16:0]              coord_v
);
    localparam int LAT = 48;
    localparam int ONE_IN = 1 << IN_FRAC_BITS;
    localparam int SH_OUT = eas_pkg::WF + 1 - OUT_FRAC_BITS;

    assign busy = 1'b0;

    // valid chain
    logic [LAT-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start};
    end

    // magnitudes, saturated to 1.0 and scaled to Q30
    function automatic eas_pkg::q30_t mag(input logic signed [15:0] s);
        logic [16:0] m;
        begin
            m = s[15] ? 17'(-{s[15], s}) : {1'b0, s};
            if (int'(m) > ONE_IN)
                m = 17'(ONE_IN);
            mag = 31'({14'd0, m} << (eas_pkg::WF - IN_FRAC_BITS));
        end
    endfunction

    eas_pkg::q30_t ax, ay, az, mx, mn;
    always_comb
    begin
        ax = mag(dir_x);
        ay = mag(dir_y);
        az = mag(dir_z);
        mx = (ax > ay) ? ax : ay;
        mn = (ax > ay) ? ay : ax;
    end

    // side bits: sx, sy, sz, swap(ax<ay)
    logic [3:0] side_reg [39];
    always_ff @(posedge clk)
    begin
        side_reg[0] <= {dir_x[15], dir_y[15], dir_z[15], (ax < ay)};
        for (int i = 1; i < 39; i++)
            side_reg[i] <= side_reg[i-1];
    end

    logic [30:0] r_root, b_quo;
    eas_sqrt u_sqrt (.clk(clk), .rad(eas_pkg::ONE_W - az), .root(r_root));
    eas_div  u_div  (.clk(clk), .num(mn), .den(mx), .quo(b_quo));

    // Horner: six stages on b, r travels alongside
    logic signed [32:0] acc_reg  [6];
    logic [30:0]        b_reg    [5];
    logic [30:0]        r_reg    [6];
    logic signed [32:0] acc_in   [6];
    logic [30:0]        b_in     [6];
    logic signed [32:0] acc_next [6];
    always_comb
    begin
        logic        neg;
        logic [32:0] ma;
        logic [63:0] p;
        logic signed [32:0] t;
        acc_in[0] = 33'(eas_pkg::POLY[6]);
        b_in[0]   = b_quo;
        for (int k = 1; k < 6; k++)
        begin
            acc_in[k] = acc_reg[k-1];
            b_in[k]   = b_reg[k-1];
        end
        for (int k = 0; k < 6; k++)
        begin
            neg = acc_in[k][32];
            ma  = neg ? 33'(-acc_in[k]) : acc_in[k];
            p   = (64'(ma) * 64'(b_in[k]) + 64'h2000_0000) >> 30;
            t   = neg ? -$signed(33'(p)) : $signed(33'(p));
            acc_next[k] = t + 33'(eas_pkg::POLY[5-k]);
        end
    end
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 6; k++)
            acc_reg[k] <= acc_next[k];
        for (int k = 0; k < 5; k++)
            b_reg[k] <= b_in[k];
        r_reg[0] <= r_root;
        for (int k = 1; k < 6; k++)
            r_reg[k] <= r_reg[k-1];
    end

    // clamp and mirror phi
    logic [30:0] phi_reg, r2_reg;
    logic [30:0] phc;
    always_comb
    begin
        if (acc_reg[5][32])
            phc = '0;
        else if (acc_reg[5] > 33'(eas_pkg::ONE_W))
            phc = eas_pkg::ONE_W;
        else
            phc = acc_reg[5][30:0];
        if (side_reg[36][0])
            phc = eas_pkg::ONE_W - phc;
    end
    always_ff @(posedge clk)
    begin
        phi_reg <= phc;
        r2_reg  <= r_reg[5];
    end

    // v = phi * r rounded
    logic [30:0] v_reg, r3_reg;
    always_ff @(posedge clk)
    begin
        v_reg  <= 31'((64'(phi_reg) * 64'(r2_reg) + 64'h2000_0000) >> 30);
        r3_reg <= r2_reg;
    end

    // u, mirror, signs
    logic signed [32:0] u4_reg, v4_reg;
    always_ff @(posedge clk)
    begin
        logic signed [32:0] uu, vv;
        uu = $signed({2'b0, r3_reg}) - $signed({2'b0, v_reg});
        vv = $signed({2'b0, v_reg});
        if (side_reg[38][1])
        begin
            vv = $signed({2'b0, eas_pkg::ONE_W}) - uu;
            uu = $signed({2'b0, eas_pkg::ONE_W}) - $signed({2'b0, v_reg});
        end
        u4_reg <= side_reg[38][3] ? -uu : uu;
        v4_reg <= side_reg[38][2] ? -vv : vv;
    end

    // output scaling with rounding and clamp
    function automatic logic [16:0] to_out(input logic signed [32:0] w);
        logic signed [33:0] n;
        logic [33:0] q;
        begin
            n = 34'(w) + 34'sd1073741824;
            if (n < 0)
                n = '0;
            if (n > 34'sd2147483648)
                n = 34'sd2147483648;
            q = (34'(n) + (34'd1 << (SH_OUT - 1))) >> SH_OUT;
            if (q > (34'd1 << OUT_FRAC_BITS))
                q = 34'd1 << OUT_FRAC_BITS;
            to_out = q[16:0];
        end
    endfunction

    logic [16:0] u_reg, vo_reg;
    always_ff @(posedge clk)
    begin
        u_reg  <= to_out(u4_reg);
        vo_reg <= to_out(v4_reg);
    end

    // pad to full latency
    localparam int PAD = LAT - 41;
    logic [33:0] pad_reg [PAD];
    always_ff @(posedge clk)
    begin
        pad_reg[0] <= {u_reg, vo_reg};
        for (int i = 1; i < PAD; i++)
            pad_reg[i] <= pad_reg[i-1];
    end

    assign done    = vld_reg[LAT-1];
    assign coord_u = pad_reg[PAD-1][33:17];
    assign coord_v = pad_reg[PAD-1][16:0];
endmodule
`default_nettype wire

### hw/rtl/eas_sqrt.sv
// Pipelined integer square root of (1-|z|)*2^60, i.e. sqrt(1-|z|) in Q30, one result bit per stage.
`default_nettype none
module eas_sqrt (
    input  wire  logic        clk,
    input  wire  logic [30:0] rad,
    output logic [30:0]       root
);
    // radicand is rad << 30, a 61-bit value; root needs 31 bits
    logic [61:0] rem_reg  [31];
    logic [30:0] res_reg  [31];
    logic [61:0] rem_in   [31];
    logic [30:0] res_in   [31];
    logic [61:0] rem_next [31];
    logic [30:0] res_next [31];

    // one result bit per register stage, MSB first
    always_comb
    begin
        logic [61:0] trial;
        rem_in[0] = {1'b0, rad, 30'd0};
        res_in[0] = '0;
        for (int i = 1; i < 31; i++)
        begin
            rem_in[i] = rem_reg[i-1];
            res_in[i] = res_reg[i-1];
        end
        for (int i = 0; i < 31; i++)
        begin
            trial = ({31'd0, res_in[i]} << (31 - i)) | (62'd1 << (2 * (30 - i)));
            if (rem_in[i] >= trial)
            begin
                rem_next[i] = rem_in[i] - trial;
                res_next[i] = res_in[i] | (31'd1 << (30 - i));
            end
            else
            begin
                rem_next[i] = rem_in[i];
                res_next[i] = res_in[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 31; i++)
        begin
            rem_reg[i] <= rem_next[i];
            res_reg[i] <= res_next[i];
        end
    end

    assign root = res_reg[30];
endmodule
`default_nettype wire

### hw/rtl/eas_div.sv
// Pipelined restoring divider: (mn << 30) / mx, one quotient bit per stage.
`default_nettype none
module eas_div (
    input  wire  logic        clk,
    input  wire  logic [30:0] num,
    input  wire  logic [30:0] den,
    output logic [30:0]       quo
);
    // quotient is at most 2^30, so 31 bits over 31 stages
    logic [30:0] rem_reg  [31];
    logic [30:0] q_reg    [31];
    logic [30:0] d_reg    [31];
    logic [30:0] rem_in   [31];
    logic [30:0] q_in     [31];
    logic [30:0] d_in     [31];
    logic [30:0] rem_next [31];
    logic [30:0] q_next   [31];

    // num <= den, so the top 30 dividend bits start below the divisor;
    // stage 0 brings in num[0], later stages bring in zeros
    always_comb
    begin
        logic [31:0] sh;
        rem_in[0] = {1'b0, num[30:1]};
        q_in[0]   = '0;
        d_in[0]   = den;
        for (int i = 1; i < 31; i++)
        begin
            rem_in[i] = rem_reg[i-1];
            q_in[i]   = q_reg[i-1];
            d_in[i]   = d_reg[i-1];
        end
        for (int i = 0; i < 31; i++)
        begin
            sh = {rem_in[i], (i == 0) ? num[0] : 1'b0};
            if (d_in[i] != '0 && sh >= {1'b0, d_in[i]})
            begin
                rem_next[i] = 31'(sh - {1'b0, d_in[i]});
                q_next[i]   = {q_in[i][29:0], 1'b1};
            end
            else
            begin
                rem_next[i] = sh[30:0];
                q_next[i]   = {q_in[i][29:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 31; i++)
        begin
            rem_reg[i] <= rem_next[i];
            q_reg[i]   <= q_next[i];
            d_reg[i]   <= d_in[i];
        end
    end

    assign quo = (d_reg[30] == '0) ? '0 : q_reg[30];
endmodule
`default_nettype wire

### hw/rtl/eas_checker.sv
// Port-level checker for the sphere-to-square mapper, bound to the top level.
`default_nettype none
module eas_props (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [16:0] coord_u,
    input wire logic [16:0] coord_v
);
    a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy asserted");
    a_u_rng: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> coord_u <= 17'h10000) else $error("u out of range");
    a_v_rng: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> coord_v <= 17'h10000) else $error("v out of range");
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 48)) else $error("done without start");
endmodule
bind equal_area_sphere_to_square eas_props u_chk (.*);
`default_nettype wire
